// ----- hdl/ess_pkg.sv -----
package ess_pkg;

    // Default sizes of the block
    localparam int TABLE_SLOTS_DEF  = 16;
    localparam int FLOOR_BITS_DEF   = 6;
    localparam int RIDER_BITS_DEF   = 8;

    // Fixed field widths
    localparam int LOAD_W    = 5;
    localparam int CAP_W     = 5;
    localparam int IDLE_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Register values after reset
    localparam int FLOOR_COUNT_RST  = 8;
    localparam int CAR_CAPACITY_RST = 4;

    // Pause limit is twice the floor count
    localparam int IDLE_SHIFT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOOR_COUNT  = 1'b0,
        CFG_CAR_CAPACITY = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_WAITING = 2'd1,
        SLOT_RIDING  = 2'd2
    } t_slot;

    typedef enum logic [2:0] {
        EV_ACCEPTED   = 3'd0,
        EV_REJECTED   = 3'd1,
        EV_DROPPED    = 3'd2,
        EV_PICKED     = 3'd3,
        EV_SAME_FLOOR = 3'd4,
        EV_MOVED      = 3'd5,
        EV_STAYED     = 3'd6,
        EV_IDLE       = 3'd7
    } t_event;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_ADD_OK      = 3'd1,
        OP_ADD_REJ     = 3'd2,
        OP_TICK_IDLE   = 3'd3,
        OP_SWEEP_START = 3'd4,
        OP_DROP        = 3'd5,
        OP_PICK        = 3'd6,
        OP_FINAL       = 3'd7
    } t_op;

    typedef struct packed {
        logic take_item;
        logic idx_clr;
        logic idx_inc;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic bad_floor;
        logic slot_empty;
        logic idx_last;
        logic out_free;
        logic sweeping;
        logic have_work;
        logic drop_hit;
        logic pick_hit;
        logic cap_full;
    } t_stat;

endpackage

// ----- hdl/ess_in_if.sv -----
interface ess_in_if import ess_pkg::*; #(
    parameter int FLOOR_BITS = FLOOR_BITS_DEF,
    parameter int RIDER_BITS = RIDER_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [FLOOR_BITS-1:0] from_floor;
    logic [FLOOR_BITS-1:0] to_floor;
    logic [RIDER_BITS-1:0] rider_id;

    modport source (output valid, mode, from_floor, to_floor, rider_id, input ready);
    modport sink   (input valid, mode, from_floor, to_floor, rider_id, output ready);
endinterface

// ----- hdl/ess_out_if.sv -----
interface ess_out_if import ess_pkg::*; #(
    parameter int FLOOR_BITS = FLOOR_BITS_DEF,
    parameter int RIDER_BITS = RIDER_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            event_res;
    logic [RIDER_BITS-1:0] event_rider;
    logic [FLOOR_BITS-1:0] floor_now;
    logic [LOAD_W-1:0]     load_now;
    logic                  going_up;
    logic                  last;

    modport source (output valid, event_res, event_rider, floor_now, load_now, going_up, last,
                    input ready);
    modport sink   (input valid, event_res, event_rider, floor_now, load_now, going_up, last,
                    output ready);
endinterface

// ----- hdl/ess_ram.sv -----
module ess_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/ess_dp.sv -----
module ess_dp import ess_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int FLOOR_BITS  = FLOOR_BITS_DEF,
    parameter int RIDER_BITS  = RIDER_BITS_DEF,
    parameter int CFG_W       = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [FLOOR_BITS-1:0] i_src,
    input  logic [FLOOR_BITS-1:0] i_dst,
    input  logic [RIDER_BITS-1:0] i_rid,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [2:0]            o_event_res,
    output logic [RIDER_BITS-1:0] o_event_rider,
    output logic [FLOOR_BITS-1:0] o_floor_now,
    output logic [LOAD_W-1:0]     o_load_now,
    output logic                  o_going_up,
    output logic                  o_last
);
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int WAIT_W = $clog2(TABLE_SLOTS + 1);
    localparam int FC_W   = FLOOR_BITS + 1;
    localparam int ENT_W  = 2 * FLOOR_BITS + RIDER_BITS;
    localparam int CMP_W  = (FC_W + 1 > IDLE_W) ? FC_W + 1 : IDLE_W;

    // Configuration
    logic [FC_W-1:0]  r_fc;
    logic [CAP_W-1:0] r_cap;

    // Captured item
    logic [FLOOR_BITS-1:0] r_src;
    logic [FLOOR_BITS-1:0] r_dst;
    logic [RIDER_BITS-1:0] r_rid;

    // Slot status and scan index
    t_slot             r_slot [TABLE_SLOTS];
    logic [SLOT_W-1:0] r_idx, n_idx;

    // Car state
    logic [FC_W-1:0]   r_car, n_car;
    logic              r_up, n_up;
    logic [LOAD_W-1:0] r_load, n_load;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic              r_sweep, n_sweep;
    logic [IDLE_W-1:0] r_idle, n_idle;

    // Output register
    logic                  r_ov;
    t_event                r_ev;
    logic [RIDER_BITS-1:0] r_er;
    logic [FLOOR_BITS-1:0] r_ef;
    logic [LOAD_W-1:0]     r_el;
    logic                  r_eu;
    logic                  r_elast;

    // Table payload memory
    logic [ENT_W-1:0]      rd_ent;
    logic [FLOOR_BITS-1:0] rd_src, rd_dst;
    logic [RIDER_BITS-1:0] rd_rid;
    logic                  ram_we;

    t_slot                 cur_slot;
    t_slot                 slot_val;
    logic                  slot_we;
    logic                  dst_here, src_here;
    logic                  have_work;
    logic [FC_W-1:0]       fc_m1, step;
    logic                  dir_n;
    logic [CMP_W-1:0]      idle_ext, idle_lim;
    logic                  emit, ev_last;
    t_event                ev;
    logic [RIDER_BITS-1:0] ev_rider;

    ess_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({r_src, r_dst, r_rid}),
        .i_raddr (n_idx),
        .o_rdata (rd_ent)
    );

    assign {rd_src, rd_dst, rd_rid} = rd_ent;

    // Status toward the controller
    assign cur_slot  = r_slot[r_idx];
    assign dst_here  = {1'b0, rd_dst} == r_car;
    assign src_here  = {1'b0, rd_src} == r_car;
    assign have_work = (r_load != '0) || (r_wait != '0);

    assign o_stat.bad_floor  = ({1'b0, r_src} >= r_fc) || ({1'b0, r_dst} >= r_fc);
    assign o_stat.slot_empty = cur_slot == SLOT_EMPTY;
    assign o_stat.idx_last   = r_idx == SLOT_W'(TABLE_SLOTS - 1);
    assign o_stat.out_free   = !r_ov || i_out_ready;
    assign o_stat.sweeping   = r_sweep;
    assign o_stat.have_work  = have_work;
    assign o_stat.drop_hit   = (cur_slot == SLOT_RIDING) && dst_here;
    assign o_stat.pick_hit   = (cur_slot == SLOT_WAITING) && src_here;
    assign o_stat.cap_full   = r_load >= r_cap;

    // Scan index
    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + SLOT_W'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Movement: turn at the ends, step one floor, clamp to the top
    assign fc_m1    = r_fc - FC_W'(1);
    assign dir_n    = (r_car >= fc_m1) ? 1'b0 : ((r_car == '0) ? 1'b1 : r_up);
    assign step     = dir_n ? r_car + FC_W'(1) : r_car - FC_W'(1);
    assign idle_ext = CMP_W'(r_idle);
    assign idle_lim = CMP_W'(r_fc) << IDLE_SHIFT;

    // Apply the operation and pick the event
    always_comb begin
        n_car    = r_car;
        n_up     = r_up;
        n_load   = r_load;
        n_wait   = r_wait;
        n_sweep  = r_sweep;
        n_idle   = r_idle;
        slot_we  = 1'b0;
        slot_val = SLOT_EMPTY;
        ram_we   = 1'b0;
        emit     = 1'b0;
        ev_last  = 1'b0;
        ev       = EV_IDLE;
        ev_rider = '0;
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_ADD_OK: begin
                ram_we   = 1'b1;
                slot_we  = 1'b1;
                slot_val = SLOT_WAITING;
                n_wait   = r_wait + WAIT_W'(1);
                emit     = 1'b1;
                ev_last  = 1'b1;
                ev       = EV_ACCEPTED;
                ev_rider = r_rid;
            end
            OP_ADD_REJ: begin
                emit     = 1'b1;
                ev_last  = 1'b1;
                ev       = EV_REJECTED;
                ev_rider = r_rid;
            end
            OP_TICK_IDLE: begin
                emit    = 1'b1;
                ev_last = 1'b1;
                ev      = EV_IDLE;
            end
            OP_SWEEP_START: begin
                if (!r_sweep) begin
                    n_sweep = 1'b1;
                    n_idle  = '0;
                end
            end
            OP_DROP: begin
                slot_we  = 1'b1;
                slot_val = SLOT_EMPTY;
                if (r_load != '0) begin
                    n_load = r_load - LOAD_W'(1);
                end
                n_idle   = '0;
                emit     = 1'b1;
                ev       = EV_DROPPED;
                ev_rider = rd_rid;
            end
            OP_PICK: begin
                slot_we  = 1'b1;
                n_wait   = r_wait - WAIT_W'(1);
                n_idle   = '0;
                emit     = 1'b1;
                ev_rider = rd_rid;
                if (dst_here) begin
                    slot_val = SLOT_EMPTY;
                    ev       = EV_SAME_FLOOR;
                end else begin
                    slot_val = SLOT_RIDING;
                    n_load   = r_load + LOAD_W'(1);
                    ev       = EV_PICKED;
                end
            end
            OP_FINAL: begin
                emit    = 1'b1;
                ev_last = 1'b1;
                if (!have_work) begin
                    n_sweep = 1'b0;
                    ev      = EV_IDLE;
                end else if (idle_ext > idle_lim) begin
                    n_idle = '0;
                    ev     = EV_STAYED;
                end else if (r_fc <= FC_W'(1)) begin
                    ev = EV_STAYED;
                end else begin
                    n_up  = dir_n;
                    n_car = (step >= r_fc) ? fc_m1 : step;
                    if (r_idle != '1) begin
                        n_idle = r_idle + IDLE_W'(1);
                    end
                    ev = EV_MOVED;
                end
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc  <= FC_W'(FLOOR_COUNT_RST);
            r_cap <= CAP_W'(CAR_CAPACITY_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FLOOR_COUNT:  r_fc  <= i_cfg_data[FC_W-1:0];
                CFG_CAR_CAPACITY: r_cap <= i_cfg_data[CAP_W-1:0];
            endcase
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_src <= i_src;
            r_dst <= i_dst;
            r_rid <= i_rid;
        end
    end

    // Slot status, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_slot[i] <= SLOT_EMPTY;
            end
        end else if (slot_we) begin
            r_slot[r_idx] <= slot_val;
        end
    end

    // Car state and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_car   <= '0;
            r_up    <= 1'b1;
            r_load  <= '0;
            r_wait  <= '0;
            r_sweep <= 1'b0;
            r_idle  <= '0;
        end else begin
            r_idx   <= n_idx;
            r_car   <= n_car;
            r_up    <= n_up;
            r_load  <= n_load;
            r_wait  <= n_wait;
            r_sweep <= n_sweep;
            r_idle  <= n_idle;
        end
    end

    // Output register: load on an event, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ev    <= ev;
            r_er    <= ev_rider;
            r_ef    <= n_car[FLOOR_BITS-1:0];
            r_el    <= n_load;
            r_eu    <= n_up;
            r_elast <= ev_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_event_res   = r_ev;
    assign o_event_rider = r_er;
    assign o_floor_now   = r_ef;
    assign o_load_now    = r_el;
    assign o_going_up    = r_eu;
    assign o_last        = r_elast;
endmodule

// ----- hdl/ess_ctrl.sv -----
module ess_ctrl import ess_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_mode,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ADD    = 6'b000010,
        ST_TSTART = 6'b000100,
        ST_DROP   = 6'b001000,
        ST_PICK   = 6'b010000,
        ST_FINAL  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = r_state == ST_IDLE;

    // Sequence one item through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '{take_item: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0, op: OP_NONE};
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    o_cmd.idx_clr   = 1'b1;
                    n_state         = i_in_mode ? ST_TSTART : ST_ADD;
                end
            end
            // Search for the lowest empty slot
            ST_ADD: begin
                if (i_stat.bad_floor || i_stat.slot_empty || i_stat.idx_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.op = (!i_stat.bad_floor && i_stat.slot_empty) ?
                                   OP_ADD_OK : OP_ADD_REJ;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_TSTART: begin
                if (!i_stat.sweeping && !i_stat.have_work) begin
                    if (i_stat.out_free) begin
                        o_cmd.op = OP_TICK_IDLE;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    o_cmd.op      = OP_SWEEP_START;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_DROP;
                end
            end
            // Drop-offs, one slot a cycle while no drop-off waits for the output register
            ST_DROP: begin
                if (!i_stat.drop_hit || i_stat.out_free) begin
                    if (i_stat.drop_hit) begin
                        o_cmd.op = OP_DROP;
                    end
                    if (i_stat.idx_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_PICK;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            // Pick-ups in slot order until the car is full or the last slot is done
            ST_PICK: begin
                if (i_stat.cap_full) begin
                    n_state = ST_FINAL;
                end else if (!i_stat.pick_hit || i_stat.out_free) begin
                    if (i_stat.pick_hit) begin
                        o_cmd.op = OP_PICK;
                    end
                    if (i_stat.idx_last) begin
                        n_state = ST_FINAL;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_FINAL;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- hdl/elevator_sweep_scheduler.sv -----
// SCAN elevator scheduler. An add item (mode 0) stores a ride request in the
// lowest empty table slot and returns one accepted or rejected result; the
// slot is found by a search of one slot a cycle. A tick item (mode 1) returns
// the drop-off and pick-up events at the current floor and ends with one
// moved, stayed or idle result flagged last; the table is walked twice through
// a single read port of the request memory, and the pick-up walk stops early
// once the car is full. A tick with nothing to do returns only an idle result.
// Every result also waits while the previous one stays untaken in the output
// register. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data
// (index 0 floor count, 1 car capacity); the user must write it only while no
// item is in flight, as the block itself does not enforce it.
module elevator_sweep_scheduler import ess_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int FLOOR_BITS  = FLOOR_BITS_DEF,
    parameter int RIDER_BITS  = RIDER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [((FLOOR_BITS + 1 > CAP_W) ? FLOOR_BITS + 1 : CAP_W)-1:0] i_cfg_data,
    ess_in_if.sink               i_req,
    ess_out_if.source            o_evt
);
    localparam int CFG_W = (FLOOR_BITS + 1 > CAP_W) ? FLOOR_BITS + 1 : CAP_W;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_req.ready = in_ready;

    ess_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_mode  (i_req.mode),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ess_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .FLOOR_BITS  (FLOOR_BITS),
        .RIDER_BITS  (RIDER_BITS),
        .CFG_W       (CFG_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_src         (i_req.from_floor),
        .i_dst         (i_req.to_floor),
        .i_rid         (i_req.rider_id),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_evt.ready),
        .o_out_valid   (o_evt.valid),
        .o_event_res   (o_evt.event_res),
        .o_event_rider (o_evt.event_rider),
        .o_floor_now   (o_evt.floor_now),
        .o_load_now    (o_evt.load_now),
        .o_going_up    (o_evt.going_up),
        .o_last        (o_evt.last)
    );
endmodule

// ----- verif/ess_tb_pkg.sv -----
package ess_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import ess_pkg::*;

    // Item kinds carried on the mode field
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Width of the configuration data port
    localparam int CFG_W = (FLOOR_BITS_DEF + 1 > CAP_W) ? FLOOR_BITS_DEF + 1 : CAP_W;

    // One predicted car event
    typedef struct packed {
        t_event                    kind;
        logic [RIDER_BITS_DEF-1:0] rider;
        logic [FLOOR_BITS_DEF-1:0] floor_at;
        logic [LOAD_W-1:0]         load;
        logic                      up;
        logic                      last;
    } t_ride_event;

endpackage

// ----- verif/ess_ride_checker.sv -----
module ess_ride_checker import ess_pkg::*; import ess_tb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ess_in_if                    i_req_bus,
    ess_out_if                   i_evt_bus,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = TABLE_SLOTS_DEF;

    // Shadow copy of the request table and the car
    t_slot                     slot_state [SLOTS];
    logic [FLOOR_BITS_DEF-1:0] slot_src   [SLOTS];
    logic [FLOOR_BITS_DEF-1:0] slot_dst   [SLOTS];
    logic [RIDER_BITS_DEF-1:0] slot_rider [SLOTS];
    logic [FLOOR_BITS_DEF-1:0] car_floor;
    logic                      car_up;
    logic [LOAD_W-1:0]         car_load;
    logic                      sweeping;
    int                        idle_floors;
    logic [FLOOR_BITS_DEF:0]   floor_count;
    logic [CAP_W-1:0]          car_cap;

    t_ride_event item_events[$];
    t_ride_event awaited_events[$];
    int          mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    task automatic reset_car();
        for (int i = 0; i < SLOTS; i++) begin
            slot_state[i] = SLOT_EMPTY;
            slot_src[i]   = '0;
            slot_dst[i]   = '0;
            slot_rider[i] = '0;
        end
        car_floor   = '0;
        car_up      = 1'b1;
        car_load    = '0;
        sweeping    = 1'b0;
        idle_floors = 0;
        floor_count = (FLOOR_BITS_DEF + 1)'(FLOOR_COUNT_RST);
        car_cap     = CAP_W'(CAR_CAPACITY_RST);
    endtask

    function automatic logic car_has_work();
        if (car_load != 0)
            return 1'b1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_state[i] == SLOT_WAITING)
                return 1'b1;
        return 1'b0;
    endfunction

    // Record an event with the car state as it stands now
    task automatic log_event(input t_event kind, input logic [RIDER_BITS_DEF-1:0] who);
        t_ride_event e;
        e.kind     = kind;
        e.rider    = who;
        e.floor_at = car_floor;
        e.load     = car_load;
        e.up       = car_up;
        e.last     = 1'b0;
        item_events.push_back(e);
    endtask

    task automatic plan_add(input logic [FLOOR_BITS_DEF-1:0] src,
                            input logic [FLOOR_BITS_DEF-1:0] dst,
                            input logic [RIDER_BITS_DEF-1:0] rid);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (free_slot < 0 && slot_state[i] == SLOT_EMPTY)
                free_slot = i;
        if (free_slot < 0 || src >= floor_count || dst >= floor_count) begin
            log_event(EV_REJECTED, rid);
        end else begin
            slot_state[free_slot] = SLOT_WAITING;
            slot_src[free_slot]   = src;
            slot_dst[free_slot]   = dst;
            slot_rider[free_slot] = rid;
            log_event(EV_ACCEPTED, rid);
        end
    endtask

    task automatic plan_tick();
        int f;
        int fc;
        if (!sweeping) begin
            if (!car_has_work()) begin
                log_event(EV_IDLE, '0);
                return;
            end
            sweeping    = 1'b1;
            idle_floors = 0;
        end
        // Drop off riders bound for this floor
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_state[i] == SLOT_RIDING && slot_dst[i] == car_floor) begin
                slot_state[i] = SLOT_EMPTY;
                if (car_load != 0)
                    car_load--;
                log_event(EV_DROPPED, slot_rider[i]);
            end
        end
        // Pick up waiting riders in slot order until the car is full
        for (int i = 0; i < SLOTS; i++) begin
            if (car_load >= car_cap)
                break;
            if (slot_state[i] == SLOT_WAITING && slot_src[i] == car_floor) begin
                if (slot_dst[i] == car_floor) begin
                    slot_state[i] = SLOT_EMPTY;
                    log_event(EV_SAME_FLOOR, slot_rider[i]);
                end else begin
                    slot_state[i] = SLOT_RIDING;
                    car_load++;
                    log_event(EV_PICKED, slot_rider[i]);
                end
            end
        end
        if (item_events.size() > 0)
            idle_floors = 0;
        fc = int'(floor_count);
        // Close the floor: idle, pause or move
        if (!car_has_work()) begin
            sweeping = 1'b0;
            log_event(EV_IDLE, '0);
        end else if (idle_floors > 2 * fc) begin
            idle_floors = 0;
            log_event(EV_STAYED, '0);
        end else if (fc <= 1) begin
            log_event(EV_STAYED, '0);
        end else begin
            f = int'(car_floor);
            if (f >= fc - 1)
                car_up = 1'b0;
            else if (f == 0)
                car_up = 1'b1;
            f = car_up ? f + 1 : f - 1;
            if (f >= fc)
                f = fc - 1;
            car_floor = f[FLOOR_BITS_DEF-1:0];
            if (idle_floors < 255)
                idle_floors++;
            log_event(EV_MOVED, '0);
        end
    endtask

    // Predict every result of one accepted item
    task automatic plan_item();
        item_events.delete();
        if (i_req_bus.mode == MODE_ADD)
            plan_add(i_req_bus.from_floor, i_req_bus.to_floor, i_req_bus.rider_id);
        else
            plan_tick();
        item_events[item_events.size() - 1].last = 1'b1;
        foreach (item_events[i])
            awaited_events.push_back(item_events[i]);
    endtask

    task automatic check_result();
        t_ride_event want;
        if (awaited_events.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("%0t: result with nothing expected: ev=%0d rider=%0d floor=%0d",
                         $realtime, i_evt_bus.event_res, i_evt_bus.event_rider,
                         i_evt_bus.floor_now);
            return;
        end
        want = awaited_events.pop_front();
        if (i_evt_bus.event_res !== want.kind || i_evt_bus.event_rider !== want.rider ||
            i_evt_bus.floor_now !== want.floor_at || i_evt_bus.load_now !== want.load ||
            i_evt_bus.going_up !== want.up || i_evt_bus.last !== want.last) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
                $display("%0t: mismatch expected ev=%0d rider=%0d floor=%0d load=%0d up=%0d last=%0d",
                         $realtime, want.kind, want.rider, want.floor_at, want.load, want.up,
                         want.last);
                $display("%0t:          actual   ev=%0d rider=%0d floor=%0d load=%0d up=%0d last=%0d",
                         $realtime, i_evt_bus.event_res, i_evt_bus.event_rider,
                         i_evt_bus.floor_now, i_evt_bus.load_now, i_evt_bus.going_up,
                         i_evt_bus.last);
            end
        end
    endtask

    // Track config writes, predict accepted items, compare results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_car();
            awaited_events.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FLOOR_COUNT)
                    floor_count = i_cfg_data[FLOOR_BITS_DEF:0];
                else if (i_cfg_idx == CFG_CAR_CAPACITY)
                    car_cap = i_cfg_data[CAP_W-1:0];
            end
            if (i_req_bus.valid && i_req_bus.ready)
                plan_item();
            if (i_evt_bus.valid && i_evt_bus.ready)
                check_result();
            o_pending <= awaited_events.size();
        end
    end

endmodule

// ----- verif/tb_elevator_sweep_scheduler.sv -----
module tb_elevator_sweep_scheduler import ess_pkg::*; import ess_tb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending_count;
    int                   cur_floors;
    bit                   send_steady;
    bit                   take_steady;
    bit                   hold_request;

    ess_in_if  req_if ();
    ess_out_if evt_if ();

    elevator_sweep_scheduler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_evt      (evt_if)
    );

    ess_ride_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req_bus    (req_if),
        .i_evt_bus    (evt_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_item(input logic mode, input int src, input int dst, input int rid);
        int gap;
        req_if.valid      <= 1'b1;
        req_if.mode       <= mode;
        req_if.from_floor <= src[FLOOR_BITS_DEF-1:0];
        req_if.to_floor   <= dst[FLOOR_BITS_DEF-1:0];
        req_if.rider_id   <= rid[RIDER_BITS_DEF-1:0];
        do @(posedge i_clk); while (!req_if.ready);
        gap = 0;
        if (!send_steady && $urandom_range(0, 99) < 35)
            gap = idle_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_regs(input int floors, input int cap);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FLOOR_COUNT;
        cfg_data <= floors[CFG_W-1:0];
        @(posedge i_clk);
        cfg_idx  <= CFG_CAR_CAPACITY;
        cfg_data <= cap[CFG_W-1:0];
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_floors = floors;
    endtask

    // Mostly in-range requests mixed with ticks
    task automatic run_rides(input int count, input int add_pct);
        int src;
        int dst;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 90) begin
                src = $urandom_range(0, cur_floors - 1);
                dst = $urandom_range(0, cur_floors - 1);
            end else begin
                src = $urandom_range(0, 63);
                dst = $urandom_range(0, 63);
            end
            if ($urandom_range(0, 99) < add_pct)
                send_item(MODE_ADD, src, dst, $urandom_range(0, 255));
            else
                send_item(MODE_TICK, src, dst, $urandom_range(0, 255));
        end
    endtask

    // Result side: random stalls plus one requested long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        evt_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = 400;
            end
            if (stall_left > 0) begin
                evt_if.ready <= 1'b0;
                stall_left--;
            end else begin
                evt_if.ready <= 1'b1;
                if (!take_steady && $urandom_range(0, 99) < 30)
                    stall_left = idle_gap();
            end
        end
    end

    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        req_if.valid      <= 1'b0;
        req_if.mode       <= MODE_ADD;
        req_if.from_floor <= '0;
        req_if.to_floor   <= '0;
        req_if.rider_id   <= '0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_FLOOR_COUNT;
        cfg_data          <= '0;
        i_rst_n           <= 1'b0;
        send_steady  = 1'b0;
        take_steady  = 1'b0;
        hold_request = 1'b0;
        cur_floors   = FLOOR_COUNT_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tick, extremes, rejects, same floor, capacity cutoff
        send_item(MODE_TICK, 63, 63, 255);
        send_item(MODE_ADD, 0, 0, 0);
        send_item(MODE_ADD, 0, 7, 255);
        send_item(MODE_ADD, 63, 0, 1);
        send_item(MODE_ADD, 0, 63, 2);
        send_item(MODE_ADD, 0, 5, 170);
        send_item(MODE_ADD, 0, 5, 85);
        send_item(MODE_ADD, 0, 5, 3);
        send_item(MODE_ADD, 0, 6, 4);
        repeat (16)
            send_item(MODE_TICK, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 255));
        drain();

        // Single floor: the car can only stay
        write_regs(1, 1);
        run_rides(30, 50);
        drain();

        // Most floors, capacity equal to the table size
        write_regs(64, 16);
        run_rides(50, 40);
        drain();

        // Fill the table while the result side holds off
        hold_request = 1'b1;
        send_steady  = 1'b1;
        run_rides(45, 85);
        send_steady  = 1'b0;
        drain();

        // Shrink the building under waiting and riding requests
        write_regs(3, 2);
        run_rides(40, 30);
        drain();

        write_regs(2, 1);
        run_rides(40, 45);
        drain();

        // No idling on either side
        send_steady = 1'b1;
        take_steady = 1'b1;
        write_regs(5, 16);
        run_rides(40, 40);
        drain();
        send_steady = 1'b0;
        take_steady = 1'b0;

        write_regs(64, 1);
        run_rides(40, 40);
        drain();

        write_regs(8, 4);
        run_rides(40, 45);
        drain();

        repeat (2 * TABLE_SLOTS_DEF + 3) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
